// ===== sv/rmtd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the run merge threshold detector.
// No dependencies; every other file of the block imports this package.
package rmtd_pkg;

    // Field widths fixed by the interface.
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int STAT_W = 3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_PENDING   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND_NOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

    // Register index decoded from paddr[2].
    localparam logic REG_MIN_RUN = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;   // clearing sweep writes one entry
        logic load;  // capture the accepted input word
        logic rd0;   // read the position and its left neighbor
        logic rd1;   // read the right neighbor
        logic chk;   // evaluate, update counters, emit the result
        logic wr;    // write the merged length at both run ends
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;  // last entry of the clearing sweep
        logic item_ok;   // the evaluated word inserts a new position
    } sts_t;

endpackage

// ===== sv/rmtd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the run merge threshold detector.
// Depends on rmtd_pkg for the command and status structs.
module rmtd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output rmtd_pkg::cmd_t cmd,
    input  rmtd_pkg::sts_t sts
);
    import rmtd_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_CHK;
            S_CHK:   state_next = sts.item_ok ? S_WR : S_IDLE;
            S_WR:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd      = '0;
        cmd.clr  = (state_reg == S_CLR);
        cmd.load = (state_reg == S_IDLE) && start;
        cmd.rd0  = (state_reg == S_RD0);
        cmd.rd1  = (state_reg == S_RD1);
        cmd.chk  = (state_reg == S_CHK);
        cmd.wr   = (state_reg == S_WR);
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // An accepted word always starts the read sequence.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_RD0))
        else $error("accepted word did not start the read sequence");

    // Evaluation is followed by the end write or by idle, never anything else.
    a_chk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |=> (state_reg == S_WR || state_reg == S_IDLE))
        else $error("bad state after evaluation");
`endif

endmodule

// ===== sv/rmtd_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the run merge threshold detector: the run length memory,
// the step and found registers and the result registers. Uses rmtd_pkg.
module rmtd_dp #(
    parameter int MACHINES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmtd_pkg::cmd_t                cmd,
    output rmtd_pkg::sts_t                sts,
    input  logic [rmtd_pkg::POS_W-1:0]    position,
    input  logic                          last_item,
    input  logic [rmtd_pkg::LEN_W-1:0]    min_run,
    output logic                          done,
    output logic [rmtd_pkg::LEN_W-1:0]    step_number,
    output logic [rmtd_pkg::LEN_W-1:0]    run_length,
    output logic [rmtd_pkg::STAT_W-1:0]   status
);
    import rmtd_pkg::*;

    localparam int AW = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam logic [16:0] MACH_V = 17'(MACHINES);

    // Run length memory, two ports.
    logic [LEN_W-1:0] mem [MACHINES];
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic             we_a;
    logic             we_b;
    logic [LEN_W-1:0] wd_a;
    logic [LEN_W-1:0] rdata_a_reg;
    logic [LEN_W-1:0] rdata_b_reg;

    logic [AW-1:0]     clr_addr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;
    logic [LEN_W-1:0]  on_reg;
    logic [LEN_W-1:0]  left_reg;
    logic [LEN_W-1:0]  right_reg;
    logic [LEN_W-1:0]  merged_reg;
    logic [LEN_W-1:0]  step_count_reg;
    logic              found_flag_reg;
    logic [LEN_W-1:0]  found_step_reg;
    logic              done_reg;
    logic [LEN_W-1:0]  step_number_reg;
    logic [LEN_W-1:0]  run_length_reg;
    logic [STAT_W-1:0] status_reg;

    logic [AW-1:0]     pos_a;
    logic              has_right;
    logic              pos_bad;
    logic [LEN_W-1:0]  right_val;
    logic [LEN_W-1:0]  merged;
    logic [LEN_W-1:0]  step_inc;
    logic              hit;

    assign pos_a     = AW'(pos_reg);
    assign has_right = (17'(pos_reg) + 17'd1) < MACH_V;
    assign pos_bad   = (17'(pos_reg) >= MACH_V) || (on_reg != '0);
    assign right_val = has_right ? rdata_a_reg : '0;
    assign merged    = left_reg + LEN_W'(1) + right_val;
    assign step_inc  = (step_count_reg != '1) ? step_count_reg + LEN_W'(1) : step_count_reg;
    assign hit       = (merged >= min_run);

    assign sts.item_ok  = cmd.chk && !found_flag_reg && !pos_bad;
    assign sts.clr_done = cmd.clr && (clr_addr_reg == AW'(MACHINES - 1));

    // Memory port selection for each step of the sequence.
    always_comb
    begin
        addr_a = pos_a;
        addr_b = pos_a - AW'(1);
        we_a   = 1'b0;
        we_b   = 1'b0;
        wd_a   = merged_reg;
        if (cmd.clr)
        begin
            addr_a = clr_addr_reg;
            we_a   = 1'b1;
            wd_a   = '0;
        end
        else if (cmd.rd1)
        begin
            addr_a = pos_a + AW'(1);
        end
        else if (cmd.chk)
        begin
            we_a = sts.item_ok;
            wd_a = merged;
        end
        else if (cmd.wr)
        begin
            addr_a = pos_a - AW'(left_reg);
            addr_b = pos_a + AW'(right_reg);
            we_a   = 1'b1;
            we_b   = 1'b1;
        end
    end

    // Memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem[addr_a] <= wd_a;
        end
        if (we_b)
        begin
            mem[addr_b] <= merged_reg;
        end
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    // Clearing sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Input word and neighbor values.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg  <= position;
            last_reg <= last_item;
        end
        if (cmd.rd1)
        begin
            on_reg   <= rdata_a_reg;
            left_reg <= (pos_reg != '0) ? rdata_b_reg : '0;
        end
        if (cmd.chk)
        begin
            right_reg  <= right_val;
            merged_reg <= merged;
        end
    end

    // Step count and found state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            found_flag_reg <= 1'b0;
            found_step_reg <= '0;
        end
        else if (sts.item_ok)
        begin
            step_count_reg <= step_inc;
            if (hit)
            begin
                found_flag_reg <= 1'b1;
                found_step_reg <= step_inc;
            end
        end
    end

    // Result word, shown for one cycle after evaluation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.chk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk)
        begin
            if (found_flag_reg)
            begin
                step_number_reg <= found_step_reg;
                run_length_reg  <= '0;
                status_reg      <= ST_ALREADY;
            end
            else if (pos_bad)
            begin
                step_number_reg <= step_count_reg;
                run_length_reg  <= '0;
                status_reg      <= ST_BAD_INDEX;
            end
            else
            begin
                step_number_reg <= step_inc;
                run_length_reg  <= merged;
                if (hit)
                begin
                    status_reg <= ST_FOUND_NOW;
                end
                else
                begin
                    status_reg <= last_reg ? ST_NOT_FOUND : ST_PENDING;
                end
            end
        end
    end

    assign done        = done_reg;
    assign step_number = step_number_reg;
    assign run_length  = run_length_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // Once a run has been found the search stays closed until reset.
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_flag_reg |=> found_flag_reg)
        else $error("found flag dropped without reset");

    // Ignored words report no run length.
    a_ignored_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_ALREADY || status_reg == ST_BAD_INDEX))
        |-> (run_length_reg == '0))
        else $error("ignored word reported a run length");

    // A found result leaves the found flag set.
    a_found_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FOUND_NOW) |-> found_flag_reg)
        else $error("found result without found flag");

    // Run ends are only ever written with a nonzero length.
    a_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (merged_reg != '0))
        else $error("zero length written at a run end");
`endif

endmodule

// ===== sv/run_merge_threshold_detector.sv =====
`timescale 1ns / 1ps
// Top level of the run merge threshold detector: configuration register,
// controller and datapath. Uses rmtd_pkg, rmtd_ctrl and rmtd_dp.
//
// Usage:
//   Input words are taken at a rising edge with start high and busy low.
//   Each word that is not ignored switches on one machine in a row; every
//   word gives exactly one result word, marked by done for one cycle; the
//   receiver cannot hold it off. An accepted word passes the read states
//   S_RD0 and S_RD1 and the check state S_CHK, and its result is registered
//   as it leaves S_CHK. A word that switches a machine on keeps busy high
//   longer for the run end write; an ignored word drops busy with done. No
//   new word is taken until busy drops. The sequence is set by the reads
//   on the two-port run length memory (position with its left neighbor,
//   then the right neighbor) and the final write of both run ends.
//   After reset the block sweeps the memory to zero, one entry a cycle, with
//   busy high; configuration writes are taken then. min_run sits at byte
//   address 0 of the APB port and resets to 1. It must be written by the
//   user only while the block is idle; the block itself does not enforce it.
module run_merge_threshold_detector #(
    parameter int MACHINES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [rmtd_pkg::POS_W-1:0]    position,
    input  logic                          last_item,
    output logic                          done,
    output logic [rmtd_pkg::LEN_W-1:0]    step_number,
    output logic [rmtd_pkg::LEN_W-1:0]    run_length,
    output logic [rmtd_pkg::STAT_W-1:0]   status
);
    import rmtd_pkg::*;

    logic [LEN_W-1:0] min_run_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    sts_t             sts;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg <= LEN_W'(1);
        end
        else if (cfg_wr)
        begin
            min_run_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_RUN) ? 32'(min_run_reg) : '0;

    // Controller.
    rmtd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Datapath.
    rmtd_dp #(
        .MACHINES (MACHINES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .position    (position),
        .last_item   (last_item),
        .min_run     (min_run_reg),
        .done        (done),
        .step_number (step_number),
        .run_length  (run_length),
        .status      (status)
    );

endmodule
